/* rtl/core/bio_pkg.sv */
package bio_pkg;

    localparam int OFF_W = 31;
    localparam int EXT_W = 16;
    localparam int MAX_DIMS_DEFAULT = 4;

    typedef struct packed {
        logic [EXT_W-1:0] rem;
        logic [OFF_W-1:0] quo;
        logic [OFF_W-1:0] acc;
        logic [OFF_W-1:0] stride;
    } bio_beat_t;

    // a zero extent behaves as an extent of one
    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
        return (e == '0) ? EXT_W'(1) : e;
    endfunction

endpackage

/* rtl/core/bio_div_cell.sv */
module bio_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  bio_pkg::bio_beat_t beat_in,
    input  logic [bio_pkg::EXT_W-1:0] divisor,
    output logic               valid_out,
    output bio_pkg::bio_beat_t beat_out
);
    import bio_pkg::*;

    logic [EXT_W:0] trial;
    logic [EXT_W:0] diff;
    bio_beat_t      beat_next;
    bio_beat_t      beat_reg;
    logic           valid_reg;

    // one restoring step: one quotient bit per cell
    always_comb
    begin
        trial     = {beat_in.rem, beat_in.quo[OFF_W-1]};
        diff      = trial - {1'b0, divisor};
        beat_next = beat_in;
        if (trial >= {1'b0, divisor})
        begin
            beat_next.rem = diff[EXT_W-1:0];
            beat_next.quo = {beat_in.quo[OFF_W-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem = trial[EXT_W-1:0];
            beat_next.quo = {beat_in.quo[OFF_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;

endmodule

/* rtl/core/bio_acc_cell.sv */
module bio_acc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  bio_pkg::bio_beat_t beat_in,
    input  logic [bio_pkg::EXT_W-1:0] in_ext,
    output logic               valid_out,
    output bio_pkg::bio_beat_t beat_out
);
    import bio_pkg::*;

    logic [OFF_W-1:0] term;
    logic [OFF_W-1:0] stride_prod;
    bio_beat_t        beat_next;
    bio_beat_t        beat_reg;
    logic             valid_reg;

    // remainder is this dimension's index; fold it in with the running stride unless the input extent is one
    always_comb
    begin
        term        = OFF_W'(beat_in.rem) * beat_in.stride;
        stride_prod = OFF_W'(in_ext) * beat_in.stride;
        beat_next   = beat_in;
        beat_next.rem    = '0;
        beat_next.stride = stride_prod;
        if (in_ext != EXT_W'(1))
        begin
            beat_next.acc = beat_in.acc + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;

endmodule

/* rtl/core/broadcast_input_offset.sv */
// Broadcast address mapping: a flat offset into the output tensor goes in on
// in_valid/in_stall, the flat offset into the broadcast input tensor comes out
// on out_valid/out_stall, together with shape_error.
// Extents are written on cfg_we/cfg_index/cfg_data: index d < MAX_DIMS is
// output extent d, MAX_DIMS + d is input extent d, outermost first. Write them
// only while no beat is in flight.
// One beat per cycle while out_stall does not hold the output.
// Each dimension is a row of 31 divider cells, one quotient bit per cell, then
// a multiply-accumulate cell; each cell holds the beat in a register.
// When out_valid is high and out_stall holds it, the whole row of cells
// freezes and in_stall rises; bubbles in the row are not squeezed out.
// Reset sets every extent to 1, empties the row and holds in_stall high.
module broadcast_input_offset #(
    parameter int MAX_DIMS = bio_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [$clog2(2*MAX_DIMS)-1:0]     cfg_index,
    input  logic [bio_pkg::EXT_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bio_pkg::OFF_W-1:0]         out_offset,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bio_pkg::OFF_W-1:0]         in_offset,
    output logic                              shape_error
);
    import bio_pkg::*;

    localparam int IDX_W = $clog2(2*MAX_DIMS);
    localparam int SPD   = OFF_W + 1;
    localparam int N     = MAX_DIMS * SPD;

    logic [EXT_W-1:0] out_ext_reg [MAX_DIMS];
    logic [EXT_W-1:0] in_ext_reg  [MAX_DIMS];
    logic [EXT_W-1:0] out_eff     [MAX_DIMS];
    logic [EXT_W-1:0] in_eff      [MAX_DIMS];
    logic             err_reg;
    logic             err_next;
    logic             en;
    logic [N:0]       valid_chain;
    bio_beat_t        beat_chain [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                out_ext_reg[d] <= EXT_W'(1);
                in_ext_reg[d]  <= EXT_W'(1);
            end
        end
        else if (cfg_we)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (cfg_index == IDX_W'(d))
                begin
                    out_ext_reg[d] <= cfg_data;
                end
                if (cfg_index == IDX_W'(MAX_DIMS + d))
                begin
                    in_ext_reg[d] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        err_next = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            out_eff[d] = eff_extent(out_ext_reg[d]);
            in_eff[d]  = eff_extent(in_ext_reg[d]);
            if (in_eff[d] > out_eff[d])
            begin
                err_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
        end
        else
        begin
            err_reg <= err_next;
        end
    end

    assign en       = !(valid_chain[N] && out_stall);
    assign in_stall = !rst_n || !en;

    assign valid_chain[0]       = in_valid && !in_stall;
    assign beat_chain[0].rem    = '0;
    assign beat_chain[0].quo    = out_offset;
    assign beat_chain[0].acc    = '0;
    assign beat_chain[0].stride = OFF_W'(1);

    // innermost dimension first
    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_dim
        for (genvar b = 0; b < OFF_W; b++)
        begin : g_bit
            bio_div_cell u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (valid_chain[k*SPD + b]),
                .beat_in   (beat_chain[k*SPD + b]),
                .divisor   (out_eff[MAX_DIMS-1-k]),
                .valid_out (valid_chain[k*SPD + b + 1]),
                .beat_out  (beat_chain[k*SPD + b + 1])
            );
        end

        bio_acc_cell u_acc (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_chain[k*SPD + OFF_W]),
            .beat_in   (beat_chain[k*SPD + OFF_W]),
            .in_ext    (in_eff[MAX_DIMS-1-k]),
            .valid_out (valid_chain[k*SPD + SPD]),
            .beat_out  (beat_chain[k*SPD + SPD])
        );

        a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
            valid_chain[k*SPD + OFF_W] |->
                beat_chain[k*SPD + OFF_W].rem < out_eff[MAX_DIMS-1-k])
            else $error("dimension index not below its output extent");
    end

    assign out_valid   = valid_chain[N];
    assign in_offset   = beat_chain[N].acc;
    assign shape_error = err_reg;

    a_beat_count : assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> $countones(valid_chain[N:1]) ==
            $past($countones(valid_chain[N:1]))
            + int'($past(in_valid && !in_stall))
            - int'($past(out_valid && !out_stall)))
        else $error("beats in flight lost or duplicated");

    a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(valid_chain[N-1:1]))
        else $error("cell row moved while the output was held");

endmodule

/* tb/tb_broadcast_input_offset.sv */
`timescale 1ns / 1ps

module tb_broadcast_input_offset;

    localparam int DIMS         = bio_pkg::MAX_DIMS_DEFAULT;
    localparam int OFF_W        = bio_pkg::OFF_W;
    localparam int EXT_W        = bio_pkg::EXT_W;
    localparam int IDX_W        = $clog2(2*DIMS);
    localparam int LATENCY      = 32*DIMS;
    localparam int OUT_EXT_BASE = 0;
    localparam int IN_EXT_BASE  = DIMS;

    typedef logic [DIMS-1:0][EXT_W-1:0] shape_t;

    typedef struct packed {
        logic [OFF_W-1:0] in_offset;
        logic             shape_error;
    } src_addr_t;

    class src_offset_tracker;
        logic [EXT_W-1:0] out_ext[DIMS];
        logic [EXT_W-1:0] in_ext[DIMS];
        src_addr_t        src_addr_q[$];
        int               mismatches;

        function new();
            for (int d = 0; d < DIMS; d++)
            begin
                out_ext[d] = EXT_W'(1);
                in_ext[d]  = EXT_W'(1);
            end
            mismatches = 0;
        endfunction

        function void set_reg(input int idx, input logic [EXT_W-1:0] val);
            if (idx < IN_EXT_BASE)
                out_ext[idx - OUT_EXT_BASE] = val;
            else if (idx < IN_EXT_BASE + DIMS)
                in_ext[idx - IN_EXT_BASE] = val;
        endfunction

        // split by output extents innermost first, rebuild by input extents
        function src_addr_t map_offset(input logic [OFF_W-1:0] off);
            logic [31:0] rest;
            logic [31:0] oe;
            logic [31:0] ie;
            logic [31:0] idx[DIMS];
            logic [63:0] acc;
            src_addr_t   r;
            rest          = 32'(off);
            acc           = '0;
            r.shape_error = 1'b0;
            for (int d = DIMS-1; d >= 0; d--)
            begin
                oe     = (out_ext[d] == '0) ? 32'd1 : 32'(out_ext[d]);
                idx[d] = rest % oe;
                rest   = rest / oe;
            end
            for (int d = 0; d < DIMS; d++)
            begin
                oe = (out_ext[d] == '0) ? 32'd1 : 32'(out_ext[d]);
                ie = (in_ext[d] == '0) ? 32'd1 : 32'(in_ext[d]);
                if (ie > oe)
                    r.shape_error = 1'b1;
                acc = acc * 64'(ie);
                if (ie != 32'd1)
                    acc = acc + 64'(idx[d]);
            end
            r.in_offset = acc[OFF_W-1:0];
            return r;
        endfunction

        function void note_offset(input logic [OFF_W-1:0] off);
            src_addr_q.push_back(map_offset(off));
        endfunction

        function void check_src_addr(input logic [OFF_W-1:0] got_off, input logic got_err);
            src_addr_t want;
            if (src_addr_q.size() == 0)
            begin
                $error("unexpected beat: in_offset %0d, shape_error %0b", got_off, got_err);
                mismatches++;
                return;
            end
            want = src_addr_q.pop_front();
            if (got_off !== want.in_offset)
            begin
                $error("in_offset: expected %0d, got %0d", want.in_offset, got_off);
                mismatches++;
            end
            if (got_err !== want.shape_error)
            begin
                $error("shape_error: expected %0b, got %0b", want.shape_error, got_err);
                mismatches++;
            end
        endfunction

        function int pending();
            return src_addr_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [EXT_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [OFF_W-1:0] out_offset;
    logic             out_valid;
    logic             out_stall;
    logic [OFF_W-1:0] in_offset;
    logic             shape_error;
    logic             press_on;

    src_offset_tracker tracker = new();

    broadcast_input_offset #(
        .MAX_DIMS(DIMS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_offset(out_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .in_offset(in_offset),
        .shape_error(shape_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.note_offset(out_offset);
        if (rst_n && out_valid && !out_stall)
            tracker.check_src_addr(in_offset, shape_error);
    end

    function automatic shape_t dims(input int e0, input int e1, input int e2, input int e3);
        shape_t s;
        s[0] = EXT_W'(e0);
        s[1] = EXT_W'(e1);
        s[2] = EXT_W'(e2);
        s[3] = EXT_W'(e3);
        return s;
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        logic [63:0] span;
        span = 64'd1;
        for (int d = 0; d < DIMS; d++)
            span = span * ((tracker.out_ext[d] == '0) ? 64'd1 : 64'(tracker.out_ext[d]));
        if (span > 64'h7FFF_0000)
            return OFF_W'($urandom);
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return OFF_W'($urandom);
            3:       return OFF_W'(span - 64'd1);
            4:       return OFF_W'(span + 64'($urandom_range(0, 1000)));
            default: return OFF_W'(64'($urandom) % span);
        endcase
    endfunction

    task automatic write_reg(input int idx, input logic [EXT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= IDX_W'(idx);
        cfg_data  <= val;
        tracker.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_shape(input shape_t oe, input shape_t ie);
        for (int d = 0; d < DIMS; d++)
        begin
            write_reg(OUT_EXT_BASE + d, oe[d]);
            write_reg(IN_EXT_BASE + d, ie[d]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_offset(input logic [OFF_W-1:0] off);
        in_valid   <= 1'b1;
        out_offset <= off;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit bursty);
        int burst;
        int gap;
        burst = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst == 0)
            begin
                gap = 0;
                if (bursty && $urandom_range(0, 2) != 0)
                    gap = $urandom_range(1, 12);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 40);
            end
            send_offset(pick_offset());
            burst--;
        end
        finish_phase();
    endtask

    // receiver: stall pattern changes mode now and then; one long hold-off
    initial
    begin : receiver
        int mode;
        int left;
        int hold;
        bit press_done;
        mode       = 0;
        left       = 0;
        hold       = 0;
        press_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (press_on && !press_done)
            begin
                press_done = 1'b1;
                hold       = 600;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((left % 5) < 2);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        shape_t oe;
        shape_t ie;
        int     pick;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        out_offset <= '0;
        press_on   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset extents: everything broadcasts
        send_offset('0);
        send_offset('1);
        finish_phase();

        // mixed broadcast, last offset in range, then beyond the output size
        set_shape(dims(3, 5, 7, 11), dims(1, 5, 1, 11));
        send_offset(OFF_W'(0));
        send_offset(OFF_W'(1154));
        send_offset(OFF_W'(1155));
        send_offset(OFF_W'(600));
        send_offset('1);
        finish_phase();

        // zero extents behave as one
        set_shape(dims(0, 0, 7, 0), dims(0, 0, 7, 0));
        send_offset(OFF_W'(6));
        send_offset(OFF_W'(13));
        send_offset('1);
        finish_phase();

        // shape error and narrower input extents
        set_shape(dims(2, 3, 4, 5), dims(65535, 2, 65535, 3));
        send_offset(OFF_W'(0));
        send_offset(OFF_W'(119));
        send_offset(OFF_W'(50));
        send_offset('1);
        finish_phase();

        set_shape(dims(65535, 65535, 65535, 65535), dims(65535, 65535, 65535, 65535));
        send_offset('0);
        send_offset('1);
        send_offset(OFF_W'($urandom));
        finish_phase();

        set_shape(dims(65535, 65535, 65535, 65535), dims(0, 0, 0, 0));
        send_offset('1);
        send_offset(OFF_W'($urandom));
        finish_phase();

        for (int p = 0; p < 12; p++)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                case ($urandom_range(0, 9))
                    0:          oe[d] = '0;
                    1:          oe[d] = EXT_W'(1);
                    2, 3, 4, 5: oe[d] = EXT_W'($urandom_range(2, 16));
                    6, 7:       oe[d] = EXT_W'($urandom_range(17, 300));
                    8:          oe[d] = EXT_W'($urandom);
                    default:    oe[d] = '1;
                endcase
                pick = $urandom_range(0, 7);
                case (pick)
                    0, 1:    ie[d] = EXT_W'(1);
                    2, 3, 4: ie[d] = oe[d];
                    5:       ie[d] = EXT_W'($urandom_range(1, (oe[d] == '0) ? 1 : oe[d]));
                    6:       ie[d] = EXT_W'($urandom);
                    default: ie[d] = '0;
                endcase
            end
            set_shape(oe, ie);
            if (p == 5)
            begin
                press_on <= 1'b1;
                run_phase(300, 1'b0);
                press_on <= 1'b0;
            end
            else
            begin
                run_phase($urandom_range(60, 120), 1'b1);
            end
        end

        repeat (LATENCY + 32) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
